FILE: sv/tbtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbtd_pkg
// shared constants, types and field layout of the touch baseline detector
// ----------------------------------------------------------------------------
package tbtd_pkg;

    // block sizing
    localparam int SENSORS     = 5;
    localparam int CAL_SAMPLES = 20;
    localparam int SAMPLE_BITS = 22;

    // fixed request fields
    localparam int SAMPLE_FIELDS = 5;
    localparam int SAMPLE_W      = 22;
    localparam int OK_W          = 5;
    localparam int SEL_W         = 3;
    localparam int NEW_THR_W     = 16;
    localparam int CMD_W         = 2;

    // request tdata layout
    localparam int OK_LSB    = SAMPLE_FIELDS * SAMPLE_W;
    localparam int SEL_LSB   = OK_LSB + OK_W;
    localparam int NTHR_LSB  = SEL_LSB + SEL_W;
    localparam int IN_DATA_W = ((NTHR_LSB + NEW_THR_W + 7) / 8) * 8;

    // result layout
    localparam int MASK_W     = 5;
    localparam int ERR_W      = 2;
    localparam int OUT_DATA_W = ((MASK_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2 + ERR_W;

    // threshold scaling: thr = floor(floor(sum / CAL_SAMPLES) * 120 / 100)
    localparam int SCALE_NUM = 120;
    localparam int SCALE_DEN = 100;

    // datapath widths
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(CAL_SAMPLES);
    localparam int AVG_BITS  = SAMPLE_BITS;
    localparam int THR_BITS  = SAMPLE_BITS + 1;
    localparam int PROD_BITS = AVG_BITS + $clog2(SCALE_NUM + 1);
    localparam int P1_W      = 2 * SUM_BITS + 1;
    localparam int P2_W      = 2 * PROD_BITS;
    localparam int CNT_BITS  = $clog2(CAL_SAMPLES + 1);

    // reciprocals, exact after one correction step
    localparam logic [SUM_BITS:0] RECIP1 =
        (SUM_BITS + 1)'((64'd1 << SUM_BITS) / CAL_SAMPLES);
    localparam logic [PROD_BITS-1:0] RECIP2 =
        PROD_BITS'((64'd1 << PROD_BITS) / SCALE_DEN);
    localparam logic [SUM_BITS-1:0]  CAL_SUM   = SUM_BITS'(CAL_SAMPLES);
    localparam logic [PROD_BITS-1:0] SCALE_N_P = PROD_BITS'(SCALE_NUM);
    localparam logic [PROD_BITS-1:0] SCALE_D_P = PROD_BITS'(SCALE_DEN);

    // threshold pipeline settle time, in cycles
    localparam int CALC_LATENCY = 6;
    localparam int LAT_BITS     = $clog2(CALC_LATENCY + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CAL = 2'd0,
        CMD_DET = 2'd1,
        CMD_SET = 2'd2
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_CAL_READ = 2'd1,
        ERR_RANGE    = 2'd2
    } t_err;

    typedef struct packed {
        logic acc;      // add sample into sum
        logic clr;      // clear sum
        logic load;     // load computed threshold
        logic set_thr;  // write new_threshold
    } t_lane_ctrl;

endpackage
`default_nettype wire

FILE: sv/touch_baseline_threshold_detect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_baseline_threshold_detect
// capacitive touch calibration, threshold and detection over parallel lanes
// ----------------------------------------------------------------------------
// channel  | dir | carries
// ---------+-----+-------------------------------------------------------------
// s_axis   | in  | one scan request: cmd on tuser, samples and args on tdata
// m_axis   | out | one result per request: touched_mask on tdata, flags on tuser
//
// one request is taken per cycle unless the block stalls; its result sits in
// the output register the next cycle. a calibration scan that completes the
// run holds s_axis_tready low while each lane's threshold pipeline (two
// reciprocal multiplies with a correction each) settles on the final sum.
// reset is synchronous, active low; it clears sums, count, thresholds and
// status. m_axis_tready low stalls the output register and, through it, input.
// ----------------------------------------------------------------------------
module touch_baseline_threshold_detect (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_0..sample_4, read_ok_mask, sensor_select, new_threshold, pad
    input  wire logic [tbtd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  wire logic [tbtd_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // touched_mask, pad
    output logic [tbtd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // status_update, calibration_done, error_code
    output logic [tbtd_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

    // request decode
    logic                                s_hs;
    tbtd_pkg::t_cmd                      w_cmd;
    logic [tbtd_pkg::OK_W-1:0]           w_ok_mask;
    logic [tbtd_pkg::SEL_W-1:0]          w_sel;
    logic [tbtd_pkg::NEW_THR_W-1:0]      w_new_thr;
    logic                                w_sel_ok;

    // lane signals
    logic [tbtd_pkg::SENSORS-1:0]        w_ok;
    logic [tbtd_pkg::SENSORS-1:0]        w_touched;
    logic [tbtd_pkg::SENSORS-1:0]        w_differs;
    logic [tbtd_pkg::SENSORS-1:0]        w_status;
    logic [tbtd_pkg::SENSORS-1:0]        w_status_next;
    logic                                w_changed;
    logic                                w_all_ok;

    // calibration control
    logic                                w_cal_acc;
    logic                                w_cal_clr;
    logic                                w_done;
    logic                                w_load;
    logic                                w_det;
    logic                                w_set;
    tbtd_pkg::t_err                      w_err;
    logic [tbtd_pkg::CNT_BITS-1:0]       r_cal_cnt;
    logic [tbtd_pkg::CNT_BITS-1:0]       n_cal_cnt;
    logic [tbtd_pkg::LAT_BITS-1:0]       r_calc_cnt;
    logic [tbtd_pkg::LAT_BITS-1:0]       n_calc_cnt;

    // output register
    logic                                r_out_valid;
    logic [tbtd_pkg::MASK_W-1:0]         r_mask;
    logic                                r_changed;
    logic                                r_done;
    tbtd_pkg::t_err                      r_err;
    logic [tbtd_pkg::MASK_W-1:0]         w_mask;

    assign s_axis_tready = (r_calc_cnt == '0) && (!r_out_valid || m_axis_tready);
    assign s_hs          = s_axis_tvalid && s_axis_tready;

    assign w_cmd     = tbtd_pkg::t_cmd'(s_axis_tuser);
    assign w_ok_mask = s_axis_tdata[tbtd_pkg::OK_LSB +: tbtd_pkg::OK_W];
    assign w_sel     = s_axis_tdata[tbtd_pkg::SEL_LSB +: tbtd_pkg::SEL_W];
    assign w_new_thr = s_axis_tdata[tbtd_pkg::NTHR_LSB +: tbtd_pkg::NEW_THR_W];
    assign w_sel_ok  = ({1'b0, w_sel} < (tbtd_pkg::SEL_W + 1)'(tbtd_pkg::SENSORS));
    assign w_all_ok  = &w_ok;

    // thresholds load once the lane pipelines have settled
    assign w_load = (r_calc_cnt == tbtd_pkg::LAT_BITS'(1));

    // command decode for the accepted request
    always_comb begin
        w_cal_acc  = 1'b0;
        w_cal_clr  = 1'b0;
        w_done     = 1'b0;
        w_det      = 1'b0;
        w_set      = 1'b0;
        w_err      = tbtd_pkg::ERR_NONE;
        n_cal_cnt  = r_cal_cnt;
        n_calc_cnt = (r_calc_cnt != '0) ? r_calc_cnt - 1'b1 : r_calc_cnt;
        if (s_hs) begin
            unique case (w_cmd)
                tbtd_pkg::CMD_CAL: begin
                    if (!w_all_ok) begin
                        // any failed read aborts the run
                        w_cal_clr = 1'b1;
                        n_cal_cnt = '0;
                        w_err     = tbtd_pkg::ERR_CAL_READ;
                    end else begin
                        w_cal_acc = 1'b1;
                        if (r_cal_cnt + 1'b1 >= tbtd_pkg::CNT_BITS'(tbtd_pkg::CAL_SAMPLES)) begin
                            // last scan: hold sums, start threshold pipeline
                            n_cal_cnt  = '0;
                            n_calc_cnt = tbtd_pkg::LAT_BITS'(tbtd_pkg::CALC_LATENCY);
                            w_done     = 1'b1;
                        end else begin
                            n_cal_cnt = r_cal_cnt + 1'b1;
                        end
                    end
                end
                tbtd_pkg::CMD_DET: begin
                    w_det = 1'b1;
                end
                tbtd_pkg::CMD_SET: begin
                    if (w_sel_ok) begin
                        w_set = 1'b1;
                    end else begin
                        w_err = tbtd_pkg::ERR_RANGE;
                    end
                end
                default: begin
                    // unused command: report status only
                end
            endcase
        end
    end

    // sensor lanes
    for (genvar i = 0; i < tbtd_pkg::SENSORS; i++) begin : g_lane
        logic [tbtd_pkg::SAMPLE_BITS-1:0] w_sample;
        tbtd_pkg::t_lane_ctrl             w_ctrl;

        if (i < tbtd_pkg::SAMPLE_FIELDS) begin : g_field
            assign w_sample = tbtd_pkg::SAMPLE_BITS'(
                s_axis_tdata[i * tbtd_pkg::SAMPLE_W +: tbtd_pkg::SAMPLE_W]);
            assign w_ok[i]  = w_ok_mask[i];
        end else begin : g_absent
            // no sample field behind this lane: always a failed read
            assign w_sample = '0;
            assign w_ok[i]  = 1'b0;
        end

        assign w_ctrl.acc     = w_cal_acc;
        assign w_ctrl.clr     = w_cal_clr || w_load;
        assign w_ctrl.load    = w_load;
        assign w_ctrl.set_thr = w_set && (w_sel == tbtd_pkg::SEL_W'(i));

        tbtd_lane u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_sample        (w_sample),
            .i_ok            (w_ok[i]),
            .i_status        (w_status[i]),
            .i_new_threshold (w_new_thr),
            .i_ctrl          (w_ctrl),
            .o_touched       (w_touched[i]),
            .o_differs       (w_differs[i])
        );
    end

    tbtd_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_touched     (w_touched),
        .i_differs     (w_differs),
        .i_det         (w_det),
        .o_status      (w_status),
        .o_status_next (w_status_next),
        .o_changed     (w_changed)
    );

    // status vector as seen on the result, zero above the sensor count
    for (genvar j = 0; j < tbtd_pkg::MASK_W; j++) begin : g_mask
        if (j < tbtd_pkg::SENSORS) begin : g_bit
            assign w_mask[j] = w_status_next[j];
        end else begin : g_zero
            assign w_mask[j] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_cnt   <= '0;
            r_calc_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cal_cnt  <= n_cal_cnt;
            r_calc_cnt <= n_calc_cnt;
            if (s_hs) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_hs) begin
            r_mask    <= w_mask;
            r_changed <= w_changed;
            r_done    <= w_done;
            r_err     <= w_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = tbtd_pkg::OUT_DATA_W'(r_mask);
    assign m_axis_tuser  = {r_err, r_done, r_changed};

endmodule
`default_nettype wire

FILE: sv/tbtd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbtd_lane
// one sensor: calibration sum, threshold, threshold divider pipeline, compare
// ----------------------------------------------------------------------------
module tbtd_lane (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [tbtd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                             i_ok,
    input  wire logic                             i_status,
    input  wire logic [tbtd_pkg::NEW_THR_W-1:0]   i_new_threshold,
    input  wire tbtd_pkg::t_lane_ctrl             i_ctrl,
    output logic                                  o_touched,
    output logic                                  o_differs
);

    logic [tbtd_pkg::SUM_BITS-1:0]  r_sum;
    logic [tbtd_pkg::THR_BITS-1:0]  r_thr;
    logic [tbtd_pkg::P1_W-1:0]      r_p1;
    logic [tbtd_pkg::AVG_BITS-1:0]  r_q0;
    logic [tbtd_pkg::AVG_BITS-1:0]  r_avg;
    logic [tbtd_pkg::PROD_BITS-1:0] r_prod;
    logic [tbtd_pkg::P2_W-1:0]      r_p2;

    logic [tbtd_pkg::P1_W-1:0]      w_p1;
    logic [tbtd_pkg::SUM_BITS-1:0]  w_q0_ext;
    logic [tbtd_pkg::SUM_BITS-1:0]  w_rem1;
    logic [tbtd_pkg::AVG_BITS-1:0]  w_avg;
    logic [tbtd_pkg::P2_W-1:0]      w_p2;
    logic [tbtd_pkg::THR_BITS-1:0]  w_q2;
    logic [tbtd_pkg::PROD_BITS-1:0] w_q2_ext;
    logic [tbtd_pkg::PROD_BITS-1:0] w_rem2;
    logic [tbtd_pkg::THR_BITS-1:0]  w_thr_calc;

    // sum / CAL_SAMPLES: reciprocal multiply, then one correction
    assign w_p1     = tbtd_pkg::P1_W'(r_sum) * tbtd_pkg::P1_W'(tbtd_pkg::RECIP1);
    assign w_q0_ext = tbtd_pkg::SUM_BITS'(r_q0);
    assign w_rem1   = r_sum - w_q0_ext * tbtd_pkg::CAL_SUM;
    assign w_avg    = r_q0 + tbtd_pkg::AVG_BITS'(w_rem1 >= tbtd_pkg::CAL_SUM);

    // avg * 120 / 100: constant multiply, reciprocal multiply, correction
    assign w_p2       = tbtd_pkg::P2_W'(r_prod) * tbtd_pkg::P2_W'(tbtd_pkg::RECIP2);
    assign w_q2       = r_p2[tbtd_pkg::PROD_BITS +: tbtd_pkg::THR_BITS];
    assign w_q2_ext   = tbtd_pkg::PROD_BITS'(w_q2);
    assign w_rem2     = r_prod - w_q2_ext * tbtd_pkg::SCALE_D_P;
    assign w_thr_calc = w_q2 + tbtd_pkg::THR_BITS'(w_rem2 >= tbtd_pkg::SCALE_D_P);

    // divider pipeline runs freely; sum is held while it settles
    always_ff @(posedge i_clk) begin
        r_p1   <= w_p1;
        r_q0   <= r_p1[tbtd_pkg::SUM_BITS +: tbtd_pkg::AVG_BITS];
        r_avg  <= w_avg;
        r_prod <= tbtd_pkg::PROD_BITS'(r_avg) * tbtd_pkg::SCALE_N_P;
        r_p2   <= w_p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_thr <= '0;
        end else begin
            if (i_ctrl.clr) begin
                r_sum <= '0;
            end else if (i_ctrl.acc) begin
                r_sum <= r_sum + tbtd_pkg::SUM_BITS'(i_sample);
            end
            if (i_ctrl.load) begin
                r_thr <= w_thr_calc;
            end else if (i_ctrl.set_thr) begin
                r_thr <= tbtd_pkg::THR_BITS'(i_new_threshold);
            end
        end
    end

    assign o_touched = i_ok && ({1'b0, i_sample} > r_thr);
    assign o_differs = i_ok && (o_touched != i_status);

endmodule
`default_nettype wire

FILE: sv/tbtd_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbtd_merge
// combines lane compare results and holds the touch status vector
// ----------------------------------------------------------------------------
module tbtd_merge (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [tbtd_pkg::SENSORS-1:0] i_touched,
    input  wire logic [tbtd_pkg::SENSORS-1:0] i_differs,
    input  wire logic                         i_det,
    output logic [tbtd_pkg::SENSORS-1:0]      o_status,
    output logic [tbtd_pkg::SENSORS-1:0]      o_status_next,
    output logic                              o_changed
);

    logic [tbtd_pkg::SENSORS-1:0] r_status;
    logic [tbtd_pkg::SENSORS-1:0] n_status;

    // replace only when a good reading disagrees with its stored bit
    assign o_changed = i_det && (|i_differs);
    assign n_status  = o_changed ? i_touched : r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
        end else begin
            r_status <= n_status;
        end
    end

    assign o_status      = r_status;
    assign o_status_next = n_status;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the touch baseline threshold detector: scans are
// streamed in with random gaps, results drained with random stalls, and a
// scoreboard predicts every result from its own copy of sums and thresholds
// ----------------------------------------------------------------------------
module tb_top;
    import tbtd_pkg::*;

    // run shape
    localparam int          RESET_CYCLES = 6;
    localparam int          RANDOM_ITEMS = 1350;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // the one command code the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_W) - 1;

    // request payload as it sits in tdata, sample_0 in the lowest bits
    typedef struct packed {
        logic [NEW_THR_W-1:0]                     new_thr;
        logic [SEL_W-1:0]                         sel;
        logic [OK_W-1:0]                          ok;
        logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0]   smp;
    } scan_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              changed;
        logic              done;
        logic [ERR_W-1:0]  err;
    } touch_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: tracks calibration sums, thresholds and touch status and
    // queues the result each accepted request should produce
    // ------------------------------------------------------------------------
    class touch_scoreboard;
        logic [SUM_BITS-1:0] cal_sum [SENSORS];
        int unsigned         cal_count;
        logic [THR_BITS-1:0] thr [SENSORS];
        logic [SENSORS-1:0]  status;
        touch_result_t       awaited[$];
        int unsigned         mismatches;

        function new();
            for (int i = 0; i < SENSORS; i++) begin
                cal_sum[i] = '0;
                thr[i]     = '0;
            end
            cal_count  = 0;
            status     = '0;
            mismatches = 0;
        endfunction

        function void clear_sums();
            for (int i = 0; i < SENSORS; i++)
                cal_sum[i] = '0;
            cal_count = 0;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, scan_t s);
            touch_result_t     r;
            logic [SENSORS-1:0] fresh;
            logic              differs;
            longint unsigned   avg;
            r = '0;
            case (cmd)
                CMD_CAL: begin
                    if (s.ok != '1) begin
                        // any failed read throws the whole run away
                        clear_sums();
                        r.err = ERR_CAL_READ;
                    end else begin
                        for (int i = 0; i < SENSORS; i++)
                            cal_sum[i] += s.smp[i];
                        cal_count++;
                        if (cal_count >= CAL_SAMPLES) begin
                            for (int i = 0; i < SENSORS; i++) begin
                                avg    = cal_sum[i] / CAL_SAMPLES;
                                thr[i] = THR_BITS'((avg * SCALE_NUM) / SCALE_DEN);
                            end
                            clear_sums();
                            r.done = 1'b1;
                        end
                    end
                end
                CMD_DET: begin
                    // failed reads stay 0 in the new vector and never vote
                    fresh   = '0;
                    differs = 1'b0;
                    for (int i = 0; i < SENSORS; i++) begin
                        if (s.ok[i]) begin
                            fresh[i] = (s.smp[i] > thr[i]);
                            if (fresh[i] != status[i])
                                differs = 1'b1;
                        end
                    end
                    if (differs) begin
                        status    = fresh;
                        r.changed = 1'b1;
                    end
                end
                CMD_SET: begin
                    if (s.sel >= SENSORS)
                        r.err = ERR_RANGE;
                    else
                        thr[s.sel] = THR_BITS'(s.new_thr);
                end
                default: ;
            endcase
            r.mask = status;
            awaited.push_back(r);
        endfunction

        function void check_result(touch_result_t got);
            touch_result_t want;
            logic          bad;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: result with none expected ",
                              "mask=%h chg=%b done=%b err=%0d"},
                             got.mask, got.changed, got.done, got.err);
                return;
            end
            want = awaited.pop_front();
            bad  = (got.mask !== want.mask) || (got.changed !== want.changed) ||
                   (got.done !== want.done) || (got.err !== want.err);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected mask=%h chg=%b done=%b err=%0d, ",
                              "got mask=%h chg=%b done=%b err=%0d"},
                             want.mask, want.changed, want.done, want.err,
                             got.mask, got.changed, got.done, got.err);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // sample_0..sample_4, read_ok_mask, sensor_select, new_threshold, pad
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // cmd
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // touched_mask, pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // status_update, calibration_done, error_code
    logic [OUT_USER_W-1:0] m_axis_tuser;

    touch_scoreboard sb = new();

    // set by the stimulus: calm drops all idling, hold_req asks the receiver
    // for one long stall
    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    touch_baseline_threshold_detect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // every field random, including the ones the command ignores
    function automatic scan_t random_scan();
        scan_t s;
        for (int i = 0; i < SAMPLE_FIELDS; i++)
            s.smp[i] = SAMPLE_W'($urandom);
        s.ok      = OK_W'($urandom);
        s.sel     = SEL_W'($urandom);
        s.new_thr = NEW_THR_W'($urandom);
        return s;
    endfunction

    // readings right at, just above and just below a threshold, plus random values and extremes
    function automatic logic [SAMPLE_W-1:0] near_threshold(logic [THR_BITS-1:0] t);
        longint unsigned v;
        case ($urandom_range(0, 5))
            0:       v = t;
            1:       v = t + 1;
            2:       v = (t == 0) ? 0 : t - 1;
            3:       v = $urandom_range(0, SAMPLE_MAX);
            4:       v = 0;
            default: v = SAMPLE_MAX;
        endcase
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    // calibration readings: full range, a noisy baseline, all max or all zero
    function automatic logic [SAMPLE_W-1:0] cal_sample(int mode, logic [SAMPLE_W-1:0] base);
        longint unsigned v;
        case (mode)
            0:       v = $urandom_range(0, SAMPLE_MAX);
            1:       v = base + $urandom_range(0, 4095);
            2:       v = SAMPLE_MAX;
            default: v = 0;
        endcase
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    // offer one request after a random gap and wait until it is taken
    task automatic send_scan(input logic [CMD_W-1:0] cmd, input scan_t s);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= IN_DATA_W'(s);
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall before each result, one long hold on request
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // monitors: note accepted requests, check accepted results
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        touch_result_t got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tuser, scan_t'(s_axis_tdata[$bits(scan_t)-1:0]));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mask    = m_axis_tdata[MASK_W-1:0];
            got.changed = m_axis_tuser[0];
            got.done    = m_axis_tuser[1];
            got.err     = m_axis_tuser[2 +: ERR_W];
            sb.check_result(got);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        scan_t                s;
        logic [NEW_THR_W-1:0] dir_thr [SENSORS];
        logic [SAMPLE_W-1:0]  base [SENSORS];
        int                   pick, mode, k, j;
        int unsigned          rand_start;
        bit                   hold_done;

        hold_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // zero readings against zero thresholds stay untouched
        s = random_scan();
        s.smp = '0;
        s.ok  = '1;
        send_scan(CMD_DET, s);
        // full-scale readings touch every sensor
        s.smp = '1;
        send_scan(CMD_DET, s);
        // all reads failed: nothing can cause a change
        s.smp = '0;
        s.ok  = '0;
        send_scan(CMD_DET, s);
        // partial reads: good sensors force the update, failed bits written 0
        s.ok = 5'b10101;
        send_scan(CMD_DET, s);

        // threshold writes at both extremes, then every out-of-range index
        dir_thr[0] = '1;
        dir_thr[1] = '0;
        dir_thr[2] = '1;
        dir_thr[3] = '0;
        dir_thr[4] = NEW_THR_W'($urandom);
        for (int i = 0; i < SENSORS; i++) begin
            s         = random_scan();
            s.sel     = SEL_W'(i);
            s.new_thr = dir_thr[i];
            send_scan(CMD_SET, s);
        end
        for (int i = SENSORS; i < (1 << SEL_W); i++) begin
            s     = random_scan();
            s.sel = SEL_W'(i);
            send_scan(CMD_SET, s);
        end

        // reading equal to its threshold is not a touch, one above is
        s    = random_scan();
        s.ok = '1;
        for (int i = 0; i < SENSORS; i++)
            s.smp[i] = SAMPLE_W'(dir_thr[i]);
        send_scan(CMD_DET, s);
        for (int i = 0; i < SENSORS; i++)
            s.smp[i] = SAMPLE_W'(dir_thr[i]) + 1'b1;
        send_scan(CMD_DET, s);

        // unused command only reports status
        send_scan(CMD_UNUSED, random_scan());

        // calibration read failures, one sensor and all sensors
        s    = random_scan();
        s.ok = 5'b11011;
        send_scan(CMD_CAL, s);
        s.ok = '0;
        send_scan(CMD_CAL, s);

        // a good calibration scan with detect and set mixed in behind it
        s     = random_scan();
        s.ok  = '1;
        s.smp = '1;
        send_scan(CMD_CAL, s);
        send_scan(CMD_DET, random_scan());
        s     = random_scan();
        s.sel = SEL_W'($urandom_range(0, SENSORS - 1));
        send_scan(CMD_SET, s);

        // --- random part, built from episodes ---
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            // one long receiver hold while the sender keeps requests coming
            if (!hold_done && items_sent - rand_start > 400) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                calm      = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // full calibration run, occasionally interleaved
                mode = $urandom_range(0, 3);
                for (int i = 0; i < SENSORS; i++)
                    base[i] = SAMPLE_W'($urandom);
                for (int n = 0; n < CAL_SAMPLES; n++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        s     = random_scan();
                        s.sel = SEL_W'($urandom_range(0, SENSORS - 1));
                        send_scan($urandom_range(0, 1) ? CMD_DET : CMD_SET, s);
                    end
                    s    = random_scan();
                    s.ok = '1;
                    for (int i = 0; i < SENSORS; i++)
                        s.smp[i] = cal_sample(mode, base[i]);
                    send_scan(CMD_CAL, s);
                end
            end else if (pick < 45) begin
                // calibration broken off by a failed read
                k = $urandom_range(0, CAL_SAMPLES - 1);
                for (int n = 0; n < k; n++) begin
                    s    = random_scan();
                    s.ok = '1;
                    send_scan(CMD_CAL, s);
                end
                s       = random_scan();
                j       = $urandom_range(0, SENSORS - 1);
                s.ok[j] = 1'b0;
                send_scan(CMD_CAL, s);
            end else if (pick < 80) begin
                // detection burst around the current thresholds
                k = $urandom_range(4, 14);
                for (int n = 0; n < k; n++) begin
                    s = random_scan();
                    if ($urandom_range(0, 3) != 0)
                        s.ok = '1;
                    for (int i = 0; i < SENSORS; i++)
                        s.smp[i] = near_threshold(sb.thr[i]);
                    send_scan(CMD_DET, s);
                end
            end else if (pick < 90) begin
                // threshold writes, some out of range
                k = $urandom_range(1, 3);
                for (int n = 0; n < k; n++) begin
                    s = random_scan();
                    case ($urandom_range(0, 3))
                        0:       s.new_thr = '0;
                        1:       s.new_thr = '1;
                        default: ;
                    endcase
                    send_scan(CMD_SET, s);
                end
            end else begin
                // noise: any command, any content
                k = $urandom_range(1, 4);
                for (int n = 0; n < k; n++)
                    send_scan(CMD_W'($urandom), random_scan());
            end
        end

        // --- wind down ---
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
sv/tbtd_pkg.sv
sv/tbtd_lane.sv
sv/tbtd_merge.sv
sv/touch_baseline_threshold_detect.sv
tb/tb_top.sv
